// File: hdl/mwc_pkg.sv
`timescale 1ns / 1ps

package mwc_pkg;

   // bus widths
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   // field widths
   localparam int POS_W    = 16;
   localparam int HEAD_W   = 9;
   localparam int THRESH_W = 10;
   localparam int GAIN_W   = 4;
   localparam int GOAL_W   = 10;
   localparam int WHEEL_W  = 8;
   localparam int MODE_W   = 3;
   localparam int WP_W     = 2;

   // register reset values
   localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd50;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd4;

   // waypoint pattern coordinates, mm
   localparam logic signed [GOAL_W-1:0] GOAL_FAR  = 10'sd400;
   localparam logic signed [GOAL_W-1:0] GOAL_SIDE = 10'sd300;
   localparam logic signed [GOAL_W-1:0] GOAL_DIAG = 10'sd200;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOP     = 3'd0,
      MODE_SQUARE   = 3'd1,
      MODE_TRIANGLE = 3'd2,
      MODE_LINE     = 3'd3,
      MODE_HOME     = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ARRIVE_THRESHOLD = 2'd0,
      CSR_POSITION_GAIN    = 2'd1,
      CSR_TURN_GAIN        = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ARRIVE,
      ST_AXIS,
      ST_DIVIDE,
      ST_MIX,
      ST_SCALE,
      ST_WHEEL
   } state_type;

   // one strobe per datapath step
   typedef struct packed {
      logic load;
      logic square;
      logic arrive;
      logic axis;
      logic divide;
      logic mix;
      logic scale;
      logic wheel;
   } cmd_type;

   typedef struct packed {
      logic signed [GOAL_W-1:0] x;
      logic signed [GOAL_W-1:0] y;
   } goal_type;

   // fixed waypoint patterns
   function automatic goal_type pattern_goal(input mode_type mode, input logic [WP_W-1:0] idx);
      goal_type g;
      g = '0;
      case (mode)
         MODE_SQUARE: begin
            g.x = idx[1] ? GOAL_FAR : '0;
            g.y = (idx == 2'd1 || idx == 2'd2) ? GOAL_SIDE : '0;
         end
         MODE_TRIANGLE: begin
            g.x = (idx == 2'd1) ? GOAL_DIAG : ((idx == 2'd3) ? -GOAL_DIAG : '0);
            g.y = idx[0] ? GOAL_DIAG : '0;
         end
         MODE_LINE: begin
            g.x = (idx == 2'd1) ? GOAL_FAR : '0;
         end
         default: ;
      endcase
      return g;
   endfunction

endpackage

// File: hdl/mwc_ctrl.sv
`timescale 1ns / 1ps

module mwc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output mwc_pkg::cmd_type cmd
);
   import mwc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ARRIVE;
         ST_ARRIVE: state_in = ST_AXIS;
         ST_AXIS:   state_in = ST_DIVIDE;
         ST_DIVIDE: state_in = ST_MIX;
         ST_MIX:    state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_WHEEL;
         ST_WHEEL:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // no transfer while reset is held
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         ST_SQUARE: cmd.square = 1'b1;
         ST_ARRIVE: cmd.arrive = 1'b1;
         ST_AXIS:   cmd.axis   = 1'b1;
         ST_DIVIDE: cmd.divide = 1'b1;
         ST_MIX:    cmd.mix    = 1'b1;
         ST_SCALE:  cmd.scale  = 1'b1;
         ST_WHEEL:  cmd.wheel  = out_free;
         default: ;
      endcase
   end

   // result slot: filled by the wheel step, emptied by a transfer
   assign rsp_valid_in = cmd.wheel ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/mwc_dpath.sv
`timescale 1ns / 1ps

module mwc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  mwc_pkg::cmd_type                    cmd,
   input  logic [mwc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_we,
   input  logic [mwc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mwc_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [mwc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import mwc_pkg::*;

   localparam int DIFF_W  = POS_W + 1;        // goal minus position
   localparam int HERR_W  = HEAD_W + 1;       // negated heading
   localparam int SQ_W    = 31;               // one squared position error
   localparam int SQH_W   = 17;               // squared heading error
   localparam int THR2_W  = 2 * THRESH_W;
   localparam int D2_W    = 32;
   localparam int PROD_W  = 22;               // error times gain
   localparam int MIX_W   = 15;               // axis times turn scale
   localparam int WSUM_W  = 10;               // three-term wheel sum
   localparam int CMD_W   = 7;

   localparam logic [7:0]         RECIP5     = 8'd205;     // 2^10 / 5, rounded up
   localparam int                 DIV5_SAT   = 505;        // |p| >= 505 clamps
   localparam logic [13:0]        RECIP100   = 14'd10486;  // 2^20 / 100, rounded up
   localparam logic [CMD_W-1:0]   AXIS_LIMIT = 7'd100;
   localparam logic signed [WSUM_W-1:0] WHEEL_LIMIT = 10'sd120;

   // truncate p/5 toward zero, clamp to +-100
   function automatic logic signed [WHEEL_W-1:0] div5_clamp(
      input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0]         mag;
      logic [16:0]               scaled;
      logic [CMD_W-1:0]          q;
      logic signed [WHEEL_W-1:0] qs;
      mag    = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      scaled = 17'(mag[8:0]) * 17'(RECIP5);
      q      = (mag >= PROD_W'(DIV5_SAT)) ? AXIS_LIMIT : scaled[16:10];
      qs     = $signed({1'b0, q});
      return p[PROD_W-1] ? -qs : qs;
   endfunction

   // truncate m/100 toward zero, |m| <= 10000
   function automatic logic signed [WHEEL_W-1:0] div100(
      input logic signed [MIX_W-1:0] m);
      logic [MIX_W-1:0]          mag;
      logic [27:0]               scaled;
      logic signed [WHEEL_W-1:0] qs;
      mag    = m[MIX_W-1] ? MIX_W'(-m) : MIX_W'(m);
      scaled = 28'(mag[13:0]) * 28'(RECIP100);
      qs     = $signed({1'b0, scaled[26:20]});
      return m[MIX_W-1] ? -qs : qs;
   endfunction

   function automatic logic signed [WHEEL_W-1:0] wheel_clamp(
      input logic signed [WSUM_W-1:0] v);
      logic signed [WSUM_W-1:0] c;
      if (v > WHEEL_LIMIT)       c = WHEEL_LIMIT;
      else if (v < -WHEEL_LIMIT) c = -WHEEL_LIMIT;
      else                       c = v;
      return c[WHEEL_W-1:0];
   endfunction

   // input fields
   logic signed [POS_W-1:0]  in_x, in_y;
   logic signed [HEAD_W-1:0] in_h;
   logic                     in_a, in_b;

   assign in_x = $signed(req_tdata[15:0]);
   assign in_y = $signed(req_tdata[31:16]);
   assign in_h = $signed(req_tdata[40:32]);
   assign in_a = req_tdata[41];
   assign in_b = req_tdata[42];

   // configuration
   logic [THRESH_W-1:0] thr_ff, thr_in;
   logic [GAIN_W-1:0]   pgain_ff, pgain_in, tgain_ff, tgain_in;

   always_comb begin
      thr_in   = thr_ff;
      pgain_in = pgain_ff;
      tgain_in = tgain_ff;
      if (csr_we) begin
         case (csr_addr_type'(csr_index))
            CSR_ARRIVE_THRESHOLD: thr_in   = csr_data[THRESH_W-1:0];
            CSR_POSITION_GAIN:    pgain_in = csr_data[GAIN_W-1:0];
            CSR_TURN_GAIN:        tgain_in = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // controller state of the waypoint machine
   mode_type                 mode_ff, mode_in;
   logic [WP_W-1:0]          wp_ff, wp_in, wp_step;
   logic signed [GOAL_W-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   goal_type                 goal_next;
   logic                     arrived;

   // captured item
   logic signed [POS_W-1:0]  px_ff, py_ff;
   logic signed [HEAD_W-1:0] hd_ff;

   // errors against the current goal
   logic signed [DIFF_W-1:0]   err_x, err_y;
   logic signed [HERR_W-1:0]   err_h;
   logic signed [2*DIFF_W-1:0] sq_full_x, sq_full_y;
   logic signed [2*HERR_W-1:0] sq_full_h;

   assign err_x     = DIFF_W'(goal_x_ff) - DIFF_W'(px_ff);
   assign err_y     = DIFF_W'(goal_y_ff) - DIFF_W'(py_ff);
   assign err_h     = -HERR_W'(hd_ff);
   assign sq_full_x = err_x * err_x;
   assign sq_full_y = err_y * err_y;
   assign sq_full_h = err_h * err_h;

   logic [SQ_W-1:0]   sq_x_ff, sq_y_ff;
   logic [SQH_W-1:0]  sq_h_ff;
   logic [THR2_W-1:0] thr2_ff;
   logic [D2_W-1:0]   dist2;

   assign dist2   = D2_W'(sq_x_ff) + D2_W'(sq_y_ff) + D2_W'(sq_h_ff);
   assign arrived = dist2 <= D2_W'(thr2_ff);

   always_comb begin
      if (mode_ff == MODE_LINE) wp_step = (wp_ff >= 2'd2) ? '0 : wp_ff + 2'd1;
      else                      wp_step = wp_ff + 2'd1;
   end

   assign goal_next = pattern_goal(mode_ff, wp_step);

   always_comb begin
      mode_in   = mode_ff;
      wp_in     = wp_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      if (cmd.load) begin
         if (in_b) begin
            wp_in     = '0;
            goal_x_in = '0;
            goal_y_in = '0;
         end
         if (in_a) begin
            case (mode_ff)
               MODE_STOP:     mode_in = MODE_SQUARE;
               MODE_SQUARE:   mode_in = MODE_TRIANGLE;
               MODE_TRIANGLE: mode_in = MODE_LINE;
               MODE_LINE:     mode_in = MODE_HOME;
               default:       mode_in = MODE_STOP;
            endcase
         end
      end else if (cmd.arrive) begin
         if (arrived && (mode_ff inside {MODE_SQUARE, MODE_TRIANGLE, MODE_LINE})) begin
            wp_in = wp_step;
            // line pattern: third index keeps the goal
            if (!(mode_ff == MODE_LINE && wp_step == 2'd2)) begin
               goal_x_in = goal_next.x;
               goal_y_in = goal_next.y;
            end
         end
         if (mode_ff == MODE_HOME) begin
            goal_x_in = '0;
            goal_y_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESH_RESET;
         pgain_ff  <= GAIN_RESET;
         tgain_ff  <= GAIN_RESET;
         mode_ff   <= MODE_STOP;
         wp_ff     <= '0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
      end else begin
         thr_ff    <= thr_in;
         pgain_ff  <= pgain_in;
         tgain_ff  <= tgain_in;
         mode_ff   <= mode_in;
         wp_ff     <= wp_in;
         goal_x_ff <= goal_x_in;
         goal_y_ff <= goal_y_in;
      end
   end

   // axis products, from the updated goal
   logic signed [GAIN_W:0]     gain_p, gain_t;
   logic signed [PROD_W-1:0]   prod_x_in, prod_y_in, prod_h_in;
   logic signed [PROD_W-1:0]   prod_x_ff, prod_y_ff, prod_h_ff;

   assign gain_p    = $signed({1'b0, pgain_ff});
   assign gain_t    = $signed({1'b0, tgain_ff});
   assign prod_x_in = PROD_W'(err_x) * PROD_W'(gain_p);
   assign prod_y_in = PROD_W'(err_y) * PROD_W'(gain_p);
   assign prod_h_in = PROD_W'(err_h) * PROD_W'(gain_t);

   // axis commands and turn scale
   logic signed [WHEEL_W-1:0] cx_in, cy_in, cz_in, cx_ff, cy_ff, cz_ff;
   logic [CMD_W-1:0]          az, scale_in, scale_ff;

   assign cx_in    = div5_clamp(prod_x_ff);
   assign cy_in    = div5_clamp(prod_y_ff);
   assign cz_in    = div5_clamp(prod_h_ff);
   assign az       = cz_in[WHEEL_W-1] ? CMD_W'(-cz_in) : CMD_W'(cz_in);
   assign scale_in = AXIS_LIMIT - az;

   logic signed [MIX_W-1:0]   mix_x_in, mix_y_in, mix_x_ff, mix_y_ff;
   logic signed [WHEEL_W:0]   scale_s;

   assign scale_s  = $signed({2'b00, scale_ff});
   assign mix_x_in = MIX_W'(cx_ff) * MIX_W'(scale_s);
   assign mix_y_in = MIX_W'(cy_ff) * MIX_W'(scale_s);

   logic signed [WHEEL_W-1:0] sx_ff, sy_ff;

   // wheel mixing
   logic signed [WSUM_W-1:0]  sum_fl, sum_fr, sum_rr, sum_rl;
   logic signed [WHEEL_W-1:0] fl_in, fr_in, rr_in, rl_in;
   logic signed [WHEEL_W-1:0] fl_ff, fr_ff, rr_ff, rl_ff;
   logic [MODE_W-1:0]         mode_out_ff;
   logic [WP_W-1:0]           wp_out_ff;

   assign sum_fl = WSUM_W'(sy_ff) + WSUM_W'(sx_ff) - WSUM_W'(cz_ff);
   assign sum_fr = WSUM_W'(sy_ff) - WSUM_W'(sx_ff) + WSUM_W'(cz_ff);
   assign sum_rr = WSUM_W'(sy_ff) - WSUM_W'(sx_ff) - WSUM_W'(cz_ff);
   assign sum_rl = WSUM_W'(sy_ff) + WSUM_W'(sx_ff) + WSUM_W'(cz_ff);

   always_comb begin
      if (mode_ff == MODE_STOP) begin
         fl_in = '0;
         fr_in = '0;
         rr_in = '0;
         rl_in = '0;
      end else begin
         fl_in = wheel_clamp(sum_fl);
         fr_in = wheel_clamp(sum_fr);
         rr_in = wheel_clamp(sum_rr);
         rl_in = wheel_clamp(sum_rl);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= in_x;
         py_ff <= in_y;
         hd_ff <= in_h;
      end
      if (cmd.square) begin
         sq_x_ff <= sq_full_x[SQ_W-1:0];
         sq_y_ff <= sq_full_y[SQ_W-1:0];
         sq_h_ff <= sq_full_h[SQH_W-1:0];
         thr2_ff <= THR2_W'(thr_ff) * THR2_W'(thr_ff);
      end
      if (cmd.axis) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_h_ff <= prod_h_in;
      end
      if (cmd.divide) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         cz_ff    <= cz_in;
         scale_ff <= scale_in;
      end
      if (cmd.mix) begin
         mix_x_ff <= mix_x_in;
         mix_y_ff <= mix_y_in;
      end
      if (cmd.scale) begin
         sx_ff <= div100(mix_x_ff);
         sy_ff <= div100(mix_y_ff);
      end
      if (cmd.wheel) begin
         fl_ff       <= fl_in;
         fr_ff       <= fr_in;
         rr_ff       <= rr_in;
         rl_ff       <= rl_in;
         mode_out_ff <= mode_ff;
         wp_out_ff   <= wp_ff;
      end
   end

   assign rsp_tdata = {3'b000, wp_out_ff, mode_out_ff, rl_ff, rr_ff, fr_ff, fl_ff};

endmodule

// File: hdl/mecanum_waypoint_controller_top.sv
`timescale 1ns / 1ps

// Mecanum waypoint controller. Each req transfer is one control tick: measured
// x/y (mm) and heading (deg) plus the two button-release flags. The block steps
// the drive mode and waypoint machine, runs the proportional x/y/turn loops and
// returns one rsp transfer with four clamped wheel speeds, the mode and the
// waypoint index. A tick occupies the sequencer for the accept cycle and seven
// datapath steps (squares, arrival test, gain products, divide-by-5 and clamp,
// turn scaling products, divide-by-100, wheel mix), at most one multiply rank
// per step; the wheel step writes the result into the output register.
// The next tick is taken as soon as the sequencer is idle again, even while
// the previous result still waits in the output register; the wheel step holds
// if that register is still full. Configuration writes (csr_index 0 threshold,
// 1 x/y gain, 2 turn gain) are accepted in any cycle outside reset and belong
// between ticks.
module mecanum_waypoint_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] position_x, [31:16] position_y, [40:32] heading,
   // [41] button_a_released, [42] button_b_released, [47:43] zero
   input  logic [mwc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] wheel_front_left, [15:8] wheel_front_right, [23:16] wheel_rear_right,
   // [31:24] wheel_rear_left, [34:32] drive_mode, [36:35] waypoint_index,
   // [39:37] zero
   output logic [mwc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mwc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mwc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mwc_pkg::*;

   cmd_type cmd;
   logic    csr_we;

   // registers take a write in any cycle outside reset
   assign csr_ready = !reset;
   assign csr_we    = csr_valid & csr_ready;

   mwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mwc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

   // a tick occupies the sequencer: no second transfer right behind it
   a_one_tick_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while a tick is in progress");

   // mode field only ever carries a defined mode
   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] <= MODE_HOME)
      else $error("drive_mode out of range");

   // stop mode drives all wheels to zero
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:32] == MODE_STOP |-> rsp_tdata[31:0] == '0)
      else $error("wheels moving in stop mode");

   // wheel clamp holds on the front left output
   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[7:0]) >= -8'sd120 &&
                     $signed(rsp_tdata[7:0]) <= 8'sd120)
      else $error("wheel speed outside clamp");

endmodule
